// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file vlsrq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define CHK_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Checked on every clock edge, reset included.
`define CHK_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("assertion failed");

`endif

// File: hw/rtl/vlsrq_pkg.sv
package vlsrq_pkg;

   localparam int BUF_SIZE = 256;
   localparam int ADDR_W   = $clog2(BUF_SIZE);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int MAX_MSG  = 64;
   localparam int LEN_W    = 6;
   localparam int TOT_W    = LEN_W + 1;
   localparam int BYTE_W   = 8;
   localparam int STAT_W   = 2;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_DATA   = 2'd1,
      OP_READ   = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [BYTE_W-1:0]  data;
      logic [LEN_W-1:0]   len;
   } cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [CNT_W-1:0]   free_space;
      logic [BYTE_W-1:0]  out_byte;
      logic               last;
   } rsp_type;

endpackage

// File: hw/rtl/variable_length_string_ring_queue_unit.sv
// Ring queue of zero-terminated messages held in a 256-byte single-port memory
// with a registered read. Commands enter a two-entry queue and are carried out
// one at a time; results leave through a two-entry queue, so either side may
// stall. A successful push start that does not fit at the tail first writes up
// to 255 padding bytes to the end of the ring, one byte a cycle. A read streams
// one result per byte of the head message, and a remove searches for the head
// message's terminator, which reads one byte a cycle. Read and remove on an
// empty queue answer with an empty status.
module variable_length_string_ring_queue_unit
   import vlsrq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        req_cmd,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [LEN_W-1:0]  req_msg_len,
   output logic              empty,
   input  logic              pop,
   output logic [STAT_W-1:0] rsp_status,
   output logic [CNT_W-1:0]  rsp_free_space,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last
);

   logic    item_valid;
   cmd_type item;
   logic    item_pop;
   logic    rsp_full;
   logic    rsp_push;
   rsp_type rsp_data;
   rsp_type rsp_head;

   vlsrq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .cmd        (req_cmd),
      .data_byte  (req_data_byte),
      .msg_len    (req_msg_len),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   vlsrq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_data)
   );

   vlsrq_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rsp_push),
      .wr_data  (rsp_data),
      .rsp_full (rsp_full),
      .empty    (empty),
      .rd_data  (rsp_head),
      .pop      (pop)
   );

   assign rsp_status     = rsp_head.status;
   assign rsp_free_space = rsp_head.free_space;
   assign rsp_out_byte   = rsp_head.out_byte;
   assign rsp_last       = rsp_head.last;

endmodule

// File: hw/rtl/vlsrq_front.sv
module vlsrq_front
   import vlsrq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        cmd,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [LEN_W-1:0]  msg_len,
   output logic              item_valid,
   output cmd_type           item,
   input  logic              item_pop
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       take;
   cmd_type    decoded;

   always_comb begin
      decoded.data = data_byte;
      decoded.len  = msg_len;
      unique case (cmd)
         OP_START: decoded.op = OP_START;
         OP_DATA:  decoded.op = OP_DATA;
         OP_READ:  decoded.op = OP_READ;
         default:  decoded.op = OP_REMOVE;
      endcase
   end

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];
   assign accept     = push && !full;
   assign take       = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: hw/rtl/vlsrq_rsp_fifo.sv
module vlsrq_rsp_fifo
   import vlsrq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  rsp_type wr_data,
   output logic    rsp_full,
   output logic    empty,
   output rsp_type rd_data,
   input  logic    pop
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       put;
   logic       take;

   assign rsp_full = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign put      = wr_en && !rsp_full;
   assign take     = pop && !empty;

   always_comb begin
      wr_ptr_in = put ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, put} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hw/rtl/vlsrq_back.sv
module vlsrq_back
   import vlsrq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    item_valid,
   input  cmd_type item,
   output logic    item_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_data
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_PAD     = 8'b0000_0010,
      S_TERM    = 8'b0000_0100,
      S_RESP    = 8'b0000_1000,
      S_RD_DATA = 8'b0001_0000,
      S_RM_DATA = 8'b0010_0000,
      S_RM_NEXT = 8'b0100_0000,
      S_RM_FIN  = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [ADDR_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [LEN_W-1:0]   left_ff, left_in;

   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [LEN_W-1:0]   lim_ff, lim_in;
   logic [ADDR_W-1:0]  start_ff, start_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   add_ff, add_in;
   logic [TOT_W-1:0]   n_ff, n_in;
   logic [ADDR_W-1:0]  next_ff, next_in;
   logic               wrap_ff, wrap_in;
   rsp_type            res_ff, res_in;

   logic [BYTE_W-1:0]  mem_ff [BUF_SIZE];
   logic [BYTE_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [BYTE_W-1:0]  mem_wdata;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;

   logic [CNT_W-1:0]   free_now;
   logic [CNT_W-1:0]   tail_sum;
   logic [ADDR_W-1:0]  tail_idx;
   logic [TOT_W-1:0]   total;
   logic               too_long;
   logic               tail_fit;
   logic [CNT_W-1:0]   pad;
   logic [CNT_W-1:0]   pad_sum;
   logic [ADDR_W-1:0]  head_inv;
   logic [LEN_W-1:0]   lim_m1;
   logic               scan_stop;
   logic [CNT_W-1:0]   release_len;
   logic [CNT_W-1:0]   used_after;
   logic [CNT_W-1:0]   used_grown;

   always_comb begin
      free_now  = CNT_W'(BUF_SIZE) - used_ff;
      tail_sum  = CNT_W'(head_ff) + used_ff;
      tail_idx  = tail_sum[ADDR_W-1:0];
      total     = TOT_W'(item.len) + TOT_W'(1);
      too_long  = total > TOT_W'(MAX_MSG);
      tail_fit  = (CNT_W'(tail_idx) + CNT_W'(total) <= CNT_W'(BUF_SIZE)) &&
                  (CNT_W'(total) <= free_now);
      pad       = CNT_W'(BUF_SIZE) - CNT_W'(tail_idx);
      pad_sum   = pad + CNT_W'(total);
      head_inv  = ~head_ff;
      lim_m1    = (head_inv > ADDR_W'(MAX_MSG - 1)) ? LEN_W'(MAX_MSG - 1)
                                                    : head_inv[LEN_W-1:0];
      scan_stop = (rd_data_ff == '0) || (cnt_ff == lim_ff);
      release_len = wrap_ff ? (CNT_W'(BUF_SIZE) - CNT_W'(head_ff)) : CNT_W'(n_ff);
      used_after  = (release_len > used_ff) ? '0 : used_ff - release_len;
      used_grown  = used_ff + add_ff;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      used_in   = used_ff;
      wr_idx_in = wr_idx_ff;
      left_in   = left_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      lim_in    = lim_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      add_in    = add_ff;
      n_in      = n_ff;
      next_in   = next_ff;
      wrap_in   = wrap_ff;
      res_in    = res_ff;
      item_pop  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = wr_idx_ff;
      mem_wdata = item.data;
      mem_re    = 1'b0;
      mem_raddr = ptr_ff + ADDR_W'(1);
      rsp_push  = 1'b0;
      rsp_data  = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               len_in   = item.len;
               unique case (item.op)
                  OP_START: begin
                     left_in = '0;
                     if (too_long || (!tail_fit && (pad_sum > free_now))) begin
                        res_in   = '{ST_NO_ROOM, free_now, '0, 1'b1};
                        state_in = S_RESP;
                     end else if (tail_fit) begin
                        start_in = tail_idx;
                        add_in   = CNT_W'(total);
                        state_in = S_TERM;
                     end else begin
                        start_in = '0;
                        add_in   = pad_sum;
                        ptr_in   = tail_idx;
                        state_in = S_PAD;
                     end
                  end
                  OP_DATA: begin
                     if (left_ff != '0) begin
                        mem_we    = 1'b1;
                        wr_idx_in = wr_idx_ff + ADDR_W'(1);
                        left_in   = left_ff - LEN_W'(1);
                     end
                     res_in   = '{ST_OK, free_now, '0, 1'b1};
                     state_in = S_RESP;
                  end
                  OP_READ, OP_REMOVE: begin
                     if (used_ff == '0) begin
                        res_in   = '{ST_EMPTY, CNT_W'(BUF_SIZE), '0, 1'b1};
                        state_in = S_RESP;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = head_ff;
                        ptr_in    = head_ff;
                        cnt_in    = '0;
                        lim_in    = lim_m1;
                        state_in  = (item.op == OP_READ) ? S_RD_DATA : S_RM_DATA;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_PAD: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = '0;
            if (ptr_ff == ADDR_W'(BUF_SIZE - 1)) begin
               state_in = S_TERM;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         S_TERM: begin
            mem_we    = 1'b1;
            mem_waddr = start_ff + ADDR_W'(len_ff);
            mem_wdata = '0;
            wr_idx_in = start_ff;
            left_in   = len_ff;
            used_in   = used_grown;
            res_in    = '{ST_OK, CNT_W'(BUF_SIZE) - used_grown, '0, 1'b1};
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RD_DATA: begin
            rsp_data = '{ST_OK, free_now, rd_data_ff, scan_stop};
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (scan_stop) begin
                  state_in = S_IDLE;
               end else begin
                  mem_re = 1'b1;
                  ptr_in = ptr_ff + ADDR_W'(1);
                  cnt_in = cnt_ff + LEN_W'(1);
               end
            end
         end
         S_RM_DATA: begin
            if (scan_stop) begin
               n_in    = TOT_W'(cnt_ff) + TOT_W'(1);
               next_in = ptr_ff + ADDR_W'(1);
               if (ptr_ff == ADDR_W'(BUF_SIZE - 1)) begin
                  wrap_in  = 1'b1;
                  state_in = S_RM_FIN;
               end else begin
                  mem_re   = 1'b1;
                  state_in = S_RM_NEXT;
               end
            end else begin
               mem_re = 1'b1;
               ptr_in = ptr_ff + ADDR_W'(1);
               cnt_in = cnt_ff + LEN_W'(1);
            end
         end
         S_RM_NEXT: begin
            wrap_in  = (rd_data_ff == '0);
            state_in = S_RM_FIN;
         end
         S_RM_FIN: begin
            used_in  = used_after;
            head_in  = (wrap_ff || (used_after == '0)) ? '0 : next_ff;
            res_in   = '{ST_OK, CNT_W'(BUF_SIZE) - used_after, '0, 1'b1};
            state_in = S_RESP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         used_ff   <= '0;
         wr_idx_ff <= '0;
         left_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         used_ff   <= used_in;
         wr_idx_ff <= wr_idx_in;
         left_ff   <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      cnt_ff   <= cnt_in;
      lim_ff   <= lim_in;
      start_ff <= start_in;
      len_ff   <= len_in;
      add_ff   <= add_in;
      n_ff     <= n_in;
      next_ff  <= next_in;
      wrap_ff  <= wrap_in;
      res_ff   <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

endmodule

// File: hw/rtl/vlsrq_checker.sv
`include "assert_macros.svh"

module vlsrq_checker
   import vlsrq_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input logic [STAT_W-1:0] rsp_status,
   input logic [CNT_W-1:0]  rsp_free_space,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_last
);

   logic [STAT_W+CNT_W+BYTE_W:0] rsp_word;
   logic                         status_legal;
   logic                         quiet_fields;
   logic                         free_all;

   assign rsp_word     = {rsp_status, rsp_free_space, rsp_out_byte, rsp_last};
   assign status_legal = (rsp_status == ST_OK) || (rsp_status == ST_NO_ROOM) ||
                         (rsp_status == ST_EMPTY);
   assign quiet_fields = rsp_last && (rsp_out_byte == '0);
   assign free_all     = (rsp_free_space == CNT_W'(BUF_SIZE));

   `CHK_RST(a_reset_clears, reset |=> (empty && !full))
   `CHK_CLK(a_rsp_holds, (!empty && !pop) |=> (!empty && $stable(rsp_word)))
   `CHK_CLK(a_empty_answer, (!empty && rsp_status == ST_EMPTY) |-> (quiet_fields && free_all))
   `CHK_CLK(a_no_room_answer, (!empty && rsp_status == ST_NO_ROOM) |-> quiet_fields)
   `CHK_CLK(a_rsp_legal, !empty |-> (status_legal && rsp_free_space <= CNT_W'(BUF_SIZE)))

endmodule

bind variable_length_string_ring_queue_unit vlsrq_checker u_checker (.*);

// File: bench/tb_variable_length_string_ring_queue_unit.sv
`timescale 1ns / 1ps

module tb_variable_length_string_ring_queue_unit;
   import vlsrq_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int TAIL_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 100;

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   logic [1:0]        req_cmd;
   logic [BYTE_W-1:0] req_data_byte;
   logic [LEN_W-1:0]  req_msg_len;
   logic              empty;
   logic              pop;
   logic [STAT_W-1:0] rsp_status;
   logic [CNT_W-1:0]  rsp_free_space;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_last;

   logic [BYTE_W-1:0] ring_mem [BUF_SIZE];
   int                head_pos;
   int                used_bytes;
   int                wr_pos;
   int                bytes_pending;
   rsp_type           expected_rsp_q [$];

   int error_count     = 0;
   int item_count      = 0;
   int result_count    = 0;
   int cycle_count     = 0;
   int no_room_count   = 0;
   int empty_hit_count = 0;
   int pad_count       = 0;
   int longest_read    = 0;
   int rx_hold_cycles  = 0;
   int burst_left      = 0;

   variable_length_string_ring_queue_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd        (req_cmd),
      .req_data_byte  (req_data_byte),
      .req_msg_len    (req_msg_len),
      .empty          (empty),
      .pop            (pop),
      .rsp_status     (rsp_status),
      .rsp_free_space (rsp_free_space),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_rsp_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int want_v, int got_v);
      error_count++;
      if (error_count <= 50) begin
         $display("%0t ns: %s expected %0d got %0d", $time, what, want_v, got_v);
      end
   endtask

   function automatic void add_expected(logic [STAT_W-1:0] st, int free_b,
                                        logic [BYTE_W-1:0] b, logic lst);
      rsp_type r;
      r.status     = st;
      r.free_space = free_b[CNT_W-1:0];
      r.out_byte   = b;
      r.last       = lst;
      expected_rsp_q.push_back(r);
   endfunction

   // Length of the message at the head, its terminator included when found.
   function automatic int head_span();
      int  lim;
      int  n;
      logic done;
      lim  = BUF_SIZE - head_pos;
      n    = 0;
      done = 1'b0;
      if (lim > MAX_MSG) begin
         lim = MAX_MSG;
      end
      while (n < lim && !done) begin
         n++;
         done = (ring_mem[head_pos + n - 1] == 8'h00);
      end
      return n;
   endfunction

   function automatic void predict_queue_step(op_type op, logic [BYTE_W-1:0] data,
                                              logic [LEN_W-1:0] len);
      int free_b;
      int total;
      int tail;
      int start;
      int pad;
      int n;
      int nxt;
      int i;
      free_b = BUF_SIZE - used_bytes;
      case (op)
         OP_START: begin
            total = int'(len) + 1;
            tail  = head_pos + used_bytes;
            start = 0;
            pad   = -1;
            if (tail >= BUF_SIZE) begin
               tail -= BUF_SIZE;
            end
            bytes_pending = 0;
            if (total <= MAX_MSG) begin
               if (tail + total <= BUF_SIZE && total <= free_b) begin
                  start = tail;
                  pad   = 0;
               end else if (BUF_SIZE - tail + total <= free_b) begin
                  pad = BUF_SIZE - tail;
                  for (i = tail; i < BUF_SIZE; i++) begin
                     ring_mem[i] = 8'h00;
                  end
                  pad_count++;
               end
            end
            if (pad < 0) begin
               no_room_count++;
               add_expected(ST_NO_ROOM, free_b, 8'h00, 1'b1);
            end else begin
               ring_mem[start + int'(len)] = 8'h00;
               wr_pos        = start;
               bytes_pending = int'(len);
               used_bytes   += pad + total;
               add_expected(ST_OK, BUF_SIZE - used_bytes, 8'h00, 1'b1);
            end
         end
         OP_DATA: begin
            if (bytes_pending != 0) begin
               if (wr_pos >= BUF_SIZE) begin
                  wr_pos = 0;
               end
               ring_mem[wr_pos] = data;
               wr_pos++;
               if (wr_pos >= BUF_SIZE) begin
                  wr_pos = 0;
               end
               bytes_pending--;
            end
            add_expected(ST_OK, free_b, 8'h00, 1'b1);
         end
         default: begin
            if (used_bytes == 0) begin
               empty_hit_count++;
               add_expected(ST_EMPTY, BUF_SIZE, 8'h00, 1'b1);
            end else if (op == OP_READ) begin
               n = head_span();
               if (n > longest_read) begin
                  longest_read = n;
               end
               for (i = 0; i < n; i++) begin
                  add_expected(ST_OK, free_b, ring_mem[head_pos + i], (i + 1 == n));
               end
            end else begin
               n   = head_span();
               nxt = head_pos + n;
               if (nxt >= BUF_SIZE || ring_mem[nxt] == 8'h00) begin
                  n        = BUF_SIZE - head_pos;
                  head_pos = 0;
               end else begin
                  head_pos = nxt;
               end
               used_bytes = (n > used_bytes) ? 0 : used_bytes - n;
               if (used_bytes == 0) begin
                  head_pos = 0;
               end
               add_expected(ST_OK, BUF_SIZE - used_bytes, 8'h00, 1'b1);
            end
         end
      endcase
   endfunction

   // Called at a rising edge. The item stays offered until it is taken.
   task automatic send_item(op_type op, logic [BYTE_W-1:0] data, logic [LEN_W-1:0] len);
      int gap;
      push          <= 1'b1;
      req_cmd       <= op;
      req_data_byte <= data;
      req_msg_len   <= len;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      predict_queue_step(op, data, len);
      item_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(30, 80);
         end else begin
            burst_left = $urandom_range(0, 12);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drain();
      push <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_rsp_q.size() != 0);
   endtask

   initial begin
      int mode;
      int mode_left;
      pop       = 1'b0;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(8, 64);
         end
         mode_left--;
         if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            pop <= 1'b0;
         end else begin
            case (mode)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(0, 1));
               default: pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         result_count++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result with no item pending, out_byte", -1, int'(rsp_out_byte));
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch("status", int'(want.status), int'(rsp_status));
            end
            if (rsp_free_space !== want.free_space) begin
               report_mismatch("free_space", int'(want.free_space), int'(rsp_free_space));
            end
            if (rsp_out_byte !== want.out_byte) begin
               report_mismatch("out_byte", int'(want.out_byte), int'(rsp_out_byte));
            end
            if (rsp_last !== want.last) begin
               report_mismatch("last", int'(want.last), int'(rsp_last));
            end
         end
      end
   end

   task automatic test_empty_queue();
      send_item(OP_READ, 8'h00, 6'd0);
      send_item(OP_REMOVE, 8'hFF, 6'd63);
      send_item(OP_DATA, 8'hFF, 6'd63);
      wait_drain();
   endtask

   // Four full-size messages fill the ring exactly, so every byte is written.
   task automatic test_fill_to_capacity();
      int m;
      int k;
      for (m = 0; m < 4; m++) begin
         send_item(OP_START, 8'h00, 6'd63);
         for (k = 0; k < 63; k++) begin
            send_item(OP_DATA, 8'($urandom_range(1, 255)), 6'($urandom));
         end
      end
      send_item(OP_START, 8'hFF, 6'd0);
      send_item(OP_READ, 8'h00, 6'd0);
      for (m = 0; m < 5; m++) begin
         send_item(OP_REMOVE, 8'($urandom), 6'($urandom));
      end
      wait_drain();
   endtask

   task automatic test_wrap_padding();
      send_item(OP_START, 8'h00, 6'd3);
      send_item(OP_DATA, 8'h01, 6'd0);
      send_item(OP_DATA, 8'h80, 6'd0);
      send_item(OP_DATA, 8'h55, 6'd0);
      send_item(OP_START, 8'h00, 6'd63);
      send_item(OP_START, 8'h00, 6'd59);
      send_item(OP_START, 8'h00, 6'd63);
      send_item(OP_START, 8'h00, 6'd60);
      send_item(OP_REMOVE, 8'h00, 6'd0);
      send_item(OP_START, 8'h00, 6'd62);
      send_item(OP_REMOVE, 8'h00, 6'd0);
      send_item(OP_START, 8'h00, 6'd3);
      send_item(OP_DATA, 8'hFF, 6'd0);
      send_item(OP_DATA, 8'h00, 6'd0);
      send_item(OP_DATA, 8'h7F, 6'd0);
      send_item(OP_REMOVE, 8'h00, 6'd0);
      send_item(OP_REMOVE, 8'h00, 6'd0);
      send_item(OP_READ, 8'h00, 6'd0);
      send_item(OP_REMOVE, 8'h00, 6'd0);
      send_item(OP_READ, 8'h00, 6'd0);
      send_item(OP_REMOVE, 8'h00, 6'd0);
      send_item(OP_READ, 8'h00, 6'd0);
      send_item(OP_REMOVE, 8'h00, 6'd0);
      wait_drain();
   endtask

   task automatic test_empty_message();
      send_item(OP_START, 8'hAA, 6'd0);
      send_item(OP_START, 8'h55, 6'd0);
      send_item(OP_READ, 8'h00, 6'd0);
      send_item(OP_REMOVE, 8'h00, 6'd0);
      send_item(OP_READ, 8'h00, 6'd0);
      wait_drain();
   endtask

   task automatic test_backpressure();
      int k;
      rx_hold_cycles = 250;
      send_item(OP_START, 8'h00, 6'd20);
      for (k = 0; k < 20; k++) begin
         send_item(OP_DATA, 8'($urandom_range(1, 255)), 6'($urandom));
      end
      send_item(OP_READ, 8'h00, 6'd0);
      send_item(OP_REMOVE, 8'h00, 6'd0);
      wait_drain();
   endtask

   task automatic test_random_traffic();
      int sent;
      int pick;
      int len;
      int cut;
      int k;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (used_bytes > 200 && pick < 60 && $urandom_range(0, 1) == 1) begin
            pick = 90;
         end
         if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(16, 63);
         end else begin
            len = $urandom_range(0, 15);
         end
         if (pick < 60) begin
            cut = (pick < 45) ? len : $urandom_range(0, len);
            send_item(OP_START, 8'($urandom), 6'(len));
            for (k = 0; k < cut; k++) begin
               send_item(OP_DATA,
                         ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
                         6'($urandom));
            end
            sent += cut + 1;
         end else if (pick < 78) begin
            send_item(OP_READ, 8'($urandom), 6'($urandom));
            sent++;
         end else if (pick < 96) begin
            send_item(OP_REMOVE, 8'($urandom), 6'($urandom));
            sent++;
         end else begin
            send_item(OP_DATA, 8'($urandom), 6'($urandom));
         end
         if ($urandom_range(0, 63) == 0) begin
            wait_drain();
         end
      end
      wait_drain();
   endtask

   initial begin
      reset         = 1'b1;
      push          = 1'b0;
      req_cmd       = OP_START;
      req_data_byte = 8'h00;
      req_msg_len   = 6'd0;
      head_pos      = 0;
      used_bytes    = 0;
      wr_pos        = 0;
      bytes_pending = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_fill_to_capacity();
      test_wrap_padding();
      test_empty_message();
      test_backpressure();
      test_random_traffic();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         report_mismatch("results never delivered", 0, expected_rsp_q.size());
      end
      $display("Sent %0d items and checked %0d results; longest read was %0d bytes.",
               item_count, result_count, longest_read);
      $display("Refused pushes %0d, empty-queue answers %0d, padded wraps %0d.",
               no_room_count, empty_hit_count, pad_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
